[design/stmc_pkg.sv]
package stmc_pkg;

  // Hard ceiling on any pulse width, in ticks
  localparam logic [14:0] PULSE_CEIL = 15'd20000;

  // Register reset values
  localparam logic [14:0] PULSE_MIN_RST   = 15'd1100;
  localparam logic [14:0] PULSE_MAX_RST   = 15'd1900;
  localparam logic [9:0]  FOLLOW_GAIN_RST = 10'd799;

  // Register indexes (byte address / 4)
  localparam logic [1:0] REG_PULSE_MIN   = 2'd0;
  localparam logic [1:0] REG_PULSE_MAX   = 2'd1;
  localparam logic [1:0] REG_FOLLOW_GAIN = 2'd2;

  // Mode codes
  localparam logic [1:0] MODE_FOLLOW = 2'd0;
  localparam logic [1:0] MODE_CENTER = 2'd1;
  localparam logic [1:0] MODE_SWEEP  = 2'd2;

  // Bar thresholds; segment k lights when the sample is strictly above entry k
  localparam logic [7:0][9:0] BAR_THR = {
    10'd1020, 10'd896, 10'd768, 10'd640, 10'd512, 10'd384, 10'd256, 10'd128
  };

  typedef struct packed {
    logic [14:0] pulse_min;
    logic [14:0] pulse_max;
    logic [9:0]  follow_gain;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic        sweep_down;
    logic [14:0] pulse;
  } state_t;

  typedef struct packed {
    logic [14:0] pulse_width;
    logic [2:0]  mode_lamps;
    logic [7:0]  bar_pattern;
  } result_t;

endpackage

[design/servo_tester_mode_controller_core.sv]
// An accepted input goes through the input register, then the result register.
// Throughput: one transaction per cycle; mode, sweep direction and pulse
//   feed back through a single register, so items wait only on an m_axis stall.
// Reset (rst_ni low, asynchronous): both pipeline stages empty, mode follow,
//   sweep upward, pulse 0, registers at 1100 / 1900 / 799.
module servo_tester_mode_controller_core
  import stmc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [9:0] adc_sample, [15:10] zero
  input  logic        s_axis_tuser,   // [0] button_event
  // Result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [7:0] bar_pattern, [10:8] mode_lamps,
                                      // [25:11] pulse_width, [31:26] zero
  // Register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t        cfg;

  // Input stage
  logic        in_vld_q;
  logic [9:0]  in_sample_q;
  logic        in_press_q;

  // Persistent controller state
  state_t      state_q;
  state_t      state_d;

  // Result stage
  logic        out_vld_q;
  result_t     out_q;
  result_t     result_d;

  logic        advance;

  assign pready = 1'b1;

  stmc_cfg_regs u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .cfg_o     (cfg)
  );

  stmc_step u_step (
    .cfg_i          (cfg),
    .state_i        (state_q),
    .adc_sample_i   (in_sample_q),
    .button_event_i (in_press_q),
    .state_o        (state_d),
    .result_o       (result_d)
  );

  // The held item moves into the result register when that slot is free or
  // being drained this cycle; state commits in the same cycle.
  assign advance       = in_vld_q & (~out_vld_q | m_axis_tready);
  assign s_axis_tready = ~in_vld_q | advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q           <= 1'b0;
      out_vld_q          <= 1'b0;
      state_q.mode       <= MODE_FOLLOW;
      state_q.sweep_down <= 1'b0;
      state_q.pulse      <= 15'd0;
    end else begin
      if (s_axis_tready) begin
        in_vld_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
        state_q   <= state_d;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_sample_q <= s_axis_tdata[9:0];
      in_press_q  <= s_axis_tuser;
    end
    if (advance) begin
      out_q <= result_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {6'd0, out_q.pulse_width, out_q.mode_lamps, out_q.bar_pattern};

endmodule

[design/stmc_cfg_regs.sv]
module stmc_cfg_regs
  import stmc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [3:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  output logic [31:0] prdata_o,
  output cfg_t        cfg_o
);

  cfg_t       cfg_q;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign reg_idx = paddr_i[3:2];
  // pready is tied high, so every access phase completes
  assign wr_en   = psel_i & penable_i & pwrite_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pulse_min   <= PULSE_MIN_RST;
      cfg_q.pulse_max   <= PULSE_MAX_RST;
      cfg_q.follow_gain <= FOLLOW_GAIN_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_PULSE_MIN:   cfg_q.pulse_min   <= pwdata_i[14:0];
        REG_PULSE_MAX:   cfg_q.pulse_max   <= pwdata_i[14:0];
        REG_FOLLOW_GAIN: cfg_q.follow_gain <= pwdata_i[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_PULSE_MIN:   prdata_o = {17'd0, cfg_q.pulse_min};
      REG_PULSE_MAX:   prdata_o = {17'd0, cfg_q.pulse_max};
      REG_FOLLOW_GAIN: prdata_o = {22'd0, cfg_q.follow_gain};
      default:         prdata_o = 32'd0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

[design/stmc_step.sv]
module stmc_step
  import stmc_pkg::*;
(
  input  cfg_t        cfg_i,
  input  state_t      state_i,
  input  logic [9:0]  adc_sample_i,
  input  logic        button_event_i,
  output state_t      state_o,
  output result_t     result_o
);

  logic [14:0] lo;
  logic [14:0] hi;
  logic [1:0]  mode_nxt;
  logic [19:0] prod;
  logic [15:0] follow_sum;
  logic [14:0] follow_pulse;
  logic [15:0] mid_sum;
  logic [14:0] up_pulse;
  logic        up_down;
  logic [14:0] dn_pulse;
  logic        dn_down;
  logic [7:0]  bar;

  assign lo = (cfg_i.pulse_min > PULSE_CEIL) ? PULSE_CEIL : cfg_i.pulse_min;
  assign hi = (cfg_i.pulse_max > PULSE_CEIL) ? PULSE_CEIL : cfg_i.pulse_max;

  // Press advances the mode; an out-of-range code wraps to follow
  always_comb begin
    if (!button_event_i) begin
      mode_nxt = state_i.mode;
    end else if (state_i.mode >= MODE_SWEEP) begin
      mode_nxt = MODE_FOLLOW;
    end else begin
      mode_nxt = state_i.mode + 2'd1;
    end
  end

  // Follow: lo + floor(sample * gain / 1024), saturated
  assign prod         = 20'(adc_sample_i) * 20'(cfg_i.follow_gain);
  assign follow_sum   = {1'b0, lo} + 16'(prod[19:10]);
  assign follow_pulse = (follow_sum > 16'(PULSE_CEIL)) ? PULSE_CEIL : follow_sum[14:0];

  // Center
  assign mid_sum = {1'b0, lo} + {1'b0, hi};

  // Sweep, up phase then down phase within one step
  always_comb begin
    if (!state_i.sweep_down) begin
      up_pulse = state_i.pulse + 15'd1;
      up_down  = (up_pulse >= hi);
    end else begin
      up_pulse = state_i.pulse;
      up_down  = 1'b1;
    end
    if (up_down) begin
      dn_pulse = (up_pulse != 15'd0) ? (up_pulse - 15'd1) : 15'd0;
      dn_down  = (dn_pulse > lo);
    end else begin
      dn_pulse = up_pulse;
      dn_down  = 1'b0;
    end
  end

  always_comb begin
    state_o.mode = mode_nxt;
    case (mode_nxt)
      MODE_FOLLOW: begin
        state_o.pulse      = follow_pulse;
        state_o.sweep_down = state_i.sweep_down;
        result_o.mode_lamps = 3'b001;
      end
      MODE_CENTER: begin
        state_o.pulse      = mid_sum[15:1];
        state_o.sweep_down = 1'b0;
        result_o.mode_lamps = 3'b010;
      end
      MODE_SWEEP: begin
        state_o.pulse      = dn_pulse;
        state_o.sweep_down = dn_down;
        result_o.mode_lamps = 3'b100;
      end
      default: begin
        state_o.pulse      = state_i.pulse;
        state_o.sweep_down = state_i.sweep_down;
        result_o.mode_lamps = 3'b000;
      end
    endcase
    result_o.bar_pattern = bar;
    result_o.pulse_width = state_o.pulse;
  end

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      bar[k] = (adc_sample_i > BAR_THR[k]);
    end
  end

endmodule

[design/stmc_checker.sv]
module stmc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata
);

  // Outputs are empty while reset is applied
  assert property (@(posedge clk_i) !rst_ni |=> !m_axis_tvalid)
    else $error("result valid during reset");

  // Mode lamps show exactly one mode
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> $onehot(m_axis_tdata[10:8]))
    else $error("mode lamps not one-hot");

  // Pulse never exceeds the ceiling
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[25:11] <= 15'd20000))
    else $error("pulse width above ceiling");

  // Bar is a thermometer code
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((m_axis_tdata[7:0] & (m_axis_tdata[7:0] + 8'd1)) == 8'd0))
    else $error("bar pattern not a thermometer code");

  // A stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");

endmodule

bind servo_tester_mode_controller_core stmc_checker u_stmc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
